// ===== hdl/ssp_pkg.sv =====
// Shared types and constants of the serial shift port.
package ssp_pkg;

    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int ACCUM_W = 10;
    localparam int INDEX_W = 3;

    localparam int DEFAULT_NORMAL_BIT_CYCLES = 512;
    localparam int DEFAULT_FAST_BIT_CYCLES   = 16;

    localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WR_DATA  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WR_CTRL  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_DATA  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RD_CTRL  = 3'd4;

    localparam logic [BYTE_W-1:0] CTRL_RESET      = 8'h7e;
    localparam logic [BYTE_W-1:0] CTRL_FORCE_MASK = 8'h7c;
    localparam int CTRL_START_BIT  = 7;
    localparam int CTRL_FAST_BIT   = 1;
    localparam int CTRL_INTCLK_BIT = 0;

    localparam logic [INDEX_W-1:0] LAST_BIT_INDEX = 3'd7;

    typedef enum logic
    {
        ST_IDLE,
        ST_SHIFT
    } ssp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic wr_data;
        logic wr_ctrl;
        logic rd_data;
        logic rd_ctrl;
        logic add_tick;
        logic shift_step;
    } ssp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic tick_active;
        logic bit_ready;
        logic step_last;
        logic slot_free;
    } ssp_sts_t;

endpackage

// ===== hdl/ssp_if.sv =====
// Valid/ready stream interfaces for the request and result channels.
interface ssp_req_if
    import ssp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] tick_cycles;

    modport source (output valid, output action, output write_data, output tick_cycles,
                    input ready);
    modport sink   (input valid, input action, input write_data, input tick_cycles,
                    output ready);
endinterface

interface ssp_rsp_if
    import ssp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              bit_valid;
    logic              out_bit;
    logic              byte_done;
    logic              last;

    modport source (output valid, output read_data, output bit_valid, output out_bit,
                    output byte_done, output last, input ready);
    modport sink   (input valid, input read_data, input bit_valid, input out_bit,
                    input byte_done, input last, output ready);
endinterface

// ===== hdl/serial_shift_port.sv =====
// Top level of the serial shift port: controller plus datapath.
// Usage:
//   req  - request channel (valid/ready). One transaction carries an action:
//          tick, write data, write control, read data or read control.
//   rsp  - result channel (valid/ready). Reads return one result; a tick returns
//          one result per bit sent, up to eight, the final one flagged by last.
//          Writes, unknown actions and ticks that send nothing return nothing.
//   cfg_we / cfg_wdata - write the color_mode bit; change it only while idle.
// Sequencing and throughput:
//   A read result is registered and appears in the cycle after the read is accepted.
//   Writes, reads and ticks with the link stopped leave the controller idle. An active
//   tick first adds its count into the accumulator, then the shift sequencer sends one
//   bit per cycle while the result channel does not stall; the request channel stays
//   blocked until the tick is done, also when it sends no bit.
//   The single result register sets the pace: one result per cycle while rsp.ready is high.
// Reset: rst_n clears the state machine and the result valid flag, loads control
//   with 0x7e, zeroes data, accumulator and bit counter, and clears color_mode.
// Stall: while rsp.ready is low a pending result holds, req.ready drops and the
//   shift sequencer holds; nothing is lost.
module serial_shift_port
    import ssp_pkg::*;
#(
    parameter int NORMAL_BIT_CYCLES = DEFAULT_NORMAL_BIT_CYCLES,
    parameter int FAST_BIT_CYCLES   = DEFAULT_FAST_BIT_CYCLES
)
(
    input  logic      clk,
    input  logic      rst_n,
    ssp_req_if.sink   req,
    ssp_rsp_if.source rsp,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    ssp_cmd_t cmd;
    ssp_sts_t sts;

    // Sequence each request and step the bit transfer.
    ssp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Hold the port registers, the cycle accumulator and the result register.
    ssp_dpath
    #(
        .NORMAL_BIT_CYCLES (NORMAL_BIT_CYCLES),
        .FAST_BIT_CYCLES   (FAST_BIT_CYCLES)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .write_data  (req.write_data),
        .tick_cycles (req.tick_cycles),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule

// ===== hdl/ssp_ctrl.sv =====
// Controller state machine of the serial shift port.
module ssp_ctrl
    import ssp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [ACT_W-1:0] req_action,
    output logic             req_ready,
    input  ssp_sts_t         sts,
    output ssp_cmd_t         cmd
);

    ssp_state_t state_reg;
    ssp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = sts.slot_free;
                if (req_valid && sts.slot_free)
                begin
                    case (req_action)
                        ACT_TICK:
                        begin
                            if (sts.tick_active)
                            begin
                                cmd.add_tick = 1'b1;
                                state_next   = ST_SHIFT;
                            end
                        end
                        ACT_WR_DATA: cmd.wr_data = 1'b1;
                        ACT_WR_CTRL: cmd.wr_ctrl = 1'b1;
                        ACT_RD_DATA: cmd.rd_data = 1'b1;
                        ACT_RD_CTRL: cmd.rd_ctrl = 1'b1;
                        default:     ; // drop unknown actions
                    endcase
                end
            end
            ST_SHIFT:
            begin
                if (sts.slot_free)
                begin
                    if (sts.bit_ready)
                    begin
                        cmd.shift_step = 1'b1;
                        if (sts.step_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/ssp_dpath.sv =====
// Datapath of the serial shift port: registers, accumulator and result register.
module ssp_dpath
    import ssp_pkg::*;
#(
    parameter int NORMAL_BIT_CYCLES = DEFAULT_NORMAL_BIT_CYCLES,
    parameter int FAST_BIT_CYCLES   = DEFAULT_FAST_BIT_CYCLES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [BYTE_W-1:0] write_data,
    input  logic [BYTE_W-1:0] tick_cycles,
    input  ssp_cmd_t          cmd,
    output ssp_sts_t          sts,
    ssp_rsp_if.source         rsp
);

    localparam logic [ACCUM_W-1:0] NORMAL_PERIOD = ACCUM_W'(NORMAL_BIT_CYCLES);
    localparam logic [ACCUM_W-1:0] FAST_PERIOD   = ACCUM_W'(FAST_BIT_CYCLES);

    logic               color_mode_reg;
    logic [BYTE_W-1:0]  shift_data_reg;
    logic [BYTE_W-1:0]  control_reg;
    logic [ACCUM_W-1:0] accum_reg;
    logic [INDEX_W-1:0] bit_index_reg;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_read_data_reg;
    logic               out_bit_valid_reg;
    logic               out_bit_reg;
    logic               out_byte_done_reg;
    logic               out_last_reg;

    logic [ACCUM_W-1:0] period;
    logic [ACCUM_W:0]   accum_sum;
    logic [ACCUM_W-1:0] accum_sat;
    logic [ACCUM_W-1:0] accum_rem;
    logic               byte_end;
    logic               out_load;

    assign period = (color_mode_reg && control_reg[CTRL_FAST_BIT]) ? FAST_PERIOD
                                                                   : NORMAL_PERIOD;
    assign accum_sum = {1'b0, accum_reg} + (ACCUM_W+1)'(tick_cycles);
    assign accum_sat = accum_sum[ACCUM_W] ? {ACCUM_W{1'b1}} : accum_sum[ACCUM_W-1:0];
    assign accum_rem = accum_reg - period;
    assign byte_end  = (bit_index_reg == LAST_BIT_INDEX);

    assign sts.tick_active = control_reg[CTRL_START_BIT] & control_reg[CTRL_INTCLK_BIT];
    assign sts.bit_ready   = (accum_reg > period);
    assign sts.step_last   = byte_end || !(accum_rem > period);
    assign sts.slot_free   = !out_valid_reg || rsp.ready;

    assign out_load = cmd.rd_data | cmd.rd_ctrl | cmd.shift_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            shift_data_reg <= '0;
            control_reg    <= CTRL_RESET;
            accum_reg      <= '0;
            bit_index_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_mode_reg <= cfg_wdata;
            end
            if (cmd.wr_data)
            begin
                shift_data_reg <= write_data;
            end
            if (cmd.wr_ctrl)
            begin
                control_reg <= write_data | CTRL_FORCE_MASK;
            end
            if (cmd.add_tick)
            begin
                accum_reg <= accum_sat;
            end
            if (cmd.shift_step)
            begin
                accum_reg      <= accum_rem;
                shift_data_reg <= {shift_data_reg[BYTE_W-2:0], 1'b1};
                bit_index_reg  <= bit_index_reg + 1'b1;
                if (byte_end)
                begin
                    control_reg[CTRL_START_BIT] <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_read_data_reg <= cmd.rd_data ? shift_data_reg :
                                 cmd.rd_ctrl ? control_reg : '0;
            out_bit_valid_reg <= cmd.shift_step;
            out_bit_reg       <= cmd.shift_step & shift_data_reg[BYTE_W-1];
            out_byte_done_reg <= cmd.shift_step & byte_end;
            out_last_reg      <= cmd.shift_step ? sts.step_last : 1'b1;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_read_data_reg;
    assign rsp.bit_valid = out_bit_valid_reg;
    assign rsp.out_bit   = out_bit_reg;
    assign rsp.byte_done = out_byte_done_reg;
    assign rsp.last      = out_last_reg;

endmodule
